FILE: hdl/ids_pkg.sv
// shared types, constants and an encoder function for the interrupt delegate
// priority select block; no dependencies
package ids_pkg;

    // register width of the hart, vector bits at or above it are ignored
    localparam int XLEN = 64;

    localparam logic [63:0] XlenMask = (XLEN >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : ((64'd1 << XLEN) - 64'd1);

    // privilege codes
    localparam logic [1:0] PrivUser    = 2'd0;
    localparam logic [1:0] PrivSuper   = 2'd1;
    localparam logic [1:0] PrivMachine = 2'd3;

    // counter overflow interrupt and the first platform-defined cause above it
    localparam int IrqLcof      = 13;
    localparam int PlatformBase = IrqLcof + 1;

    localparam logic [63:0] PlatformMask = 64'hFFFF_FFFF_FFFF_FFFF << PlatformBase;

    // fixed priority order of the standard causes, highest first
    localparam int PrioCount = 10;
    localparam logic [5:0] IrqMei  = 6'd11;
    localparam logic [5:0] IrqMsi  = 6'd3;
    localparam logic [5:0] IrqMti  = 6'd7;
    localparam logic [5:0] IrqSei  = 6'd9;
    localparam logic [5:0] IrqSsi  = 6'd1;
    localparam logic [5:0] IrqSti  = 6'd5;
    localparam logic [5:0] IrqLcf  = 6'd13;
    localparam logic [5:0] IrqVsei = 6'd10;
    localparam logic [5:0] IrqVssi = 6'd2;
    localparam logic [5:0] IrqVsti = 6'd6;

    localparam logic [5:0] PrioOrder [PrioCount] = '{
        IrqMei, IrqMsi, IrqMti, IrqSei, IrqSsi,
        IrqSti, IrqLcf, IrqVsei, IrqVssi, IrqVsti
    };

    // input beat
    typedef struct packed {
        logic [63:0] pending;
        logic [63:0] machine_delegation;
        logic [63:0] hyper_delegation;
        logic        machine_enable;
        logic        super_enable;
        logic [1:0]  priv_level;
        logic        virtualized;
        logic        in_debug;
        logic        nmi_enable;
    } ids_in_t;

    // result beat
    typedef struct packed {
        logic       take;
        logic [5:0] cause_code;
        logic       wake;
    } ids_out_t;

    // first stage: per-level candidate vectors
    typedef struct packed {
        logic        valid;
        logic [63:0] en_m;
        logic [63:0] en_hs;
        logic [63:0] en_vs;
        logic        blocked;
        logic        wake;
    } ids_mask_t;

    // second stage: chosen level vector
    typedef struct packed {
        logic        valid;
        logic [63:0] en;
        logic        take;
        logic        wake;
    } ids_sel_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [5:0] lowest_bit(input logic [63:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: hdl/ids_level_mask.sv
// first pipeline stage: masks the pending vector for machine, hs and vs level
// depends on ids_pkg
module ids_level_mask (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ids_pkg::ids_in_t  cmd,
    output ids_pkg::ids_mask_t stage
);

    logic [63:0] pend;
    logic [63:0] mdel;
    logic [63:0] hdel;
    logic        m_ok;
    logic        hs_ok;
    logic        vs_ok;
    logic        valid_reg;
    logic        valid_next;
    ids_pkg::ids_mask_t data_reg;
    ids_pkg::ids_mask_t data_next;

    // drop bits beyond the register width
    assign pend = cmd.pending & ids_pkg::XlenMask;
    assign mdel = cmd.machine_delegation & ids_pkg::XlenMask;
    assign hdel = cmd.hyper_delegation & ids_pkg::XlenMask;

    // global enable rule of each level
    assign vs_ok = (cmd.priv_level == ids_pkg::PrivUser)
                || ((cmd.priv_level == ids_pkg::PrivSuper) && cmd.super_enable);
    assign hs_ok = cmd.virtualized || vs_ok;
    assign m_ok  = (cmd.priv_level != ids_pkg::PrivMachine) || cmd.machine_enable;

    // candidate vectors
    always_comb
    begin
        data_next         = '0;
        data_next.valid   = start;
        data_next.en_m    = m_ok ? (pend & ~mdel) : 64'd0;
        data_next.en_hs   = hs_ok ? (pend & mdel & ~hdel) : 64'd0;
        data_next.en_vs   = (cmd.virtualized && vs_ok) ? (pend & hdel) : 64'd0;
        data_next.blocked = cmd.in_debug || !cmd.nmi_enable;
        data_next.wake    = |pend;
        valid_next        = start;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

FILE: hdl/ids_level_select.sv
// second pipeline stage: picks the first non-empty level and decides take
// depends on ids_pkg
module ids_level_select (
    input  logic               clk,
    input  logic               rst_n,
    input  ids_pkg::ids_mask_t mask_in,
    output ids_pkg::ids_sel_t  stage
);

    logic [63:0] en;
    logic        take;
    logic        valid_reg;
    ids_pkg::ids_sel_t data_reg;
    ids_pkg::ids_sel_t data_next;

    // machine first, then hs, then vs
    always_comb
    begin
        if (mask_in.en_m != 64'd0)
        begin
            en = mask_in.en_m;
        end
        else if (mask_in.en_hs != 64'd0)
        begin
            en = mask_in.en_hs;
        end
        else
        begin
            en = mask_in.en_vs;
        end
    end

    assign take = !mask_in.blocked && (en != 64'd0);

    // clear the vector when no trap so the cause reads zero
    always_comb
    begin
        data_next       = '0;
        data_next.valid = mask_in.valid;
        data_next.en    = take ? en : 64'd0;
        data_next.take  = take;
        data_next.wake  = mask_in.wake;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= mask_in.valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

FILE: hdl/ids_encode.sv
// third and fourth pipeline stages: priority encode and result register
// depends on ids_pkg
module ids_encode (
    input  logic              clk,
    input  logic              rst_n,
    input  ids_pkg::ids_sel_t sel_in,
    output logic              done,
    output ids_pkg::ids_out_t result
);

    logic       hi_hit_next;
    logic [5:0] hi_idx_next;
    logic       prio_hit_next;
    logic [5:0] prio_code_next;
    logic [5:0] low_idx_next;

    logic       valid_reg;
    logic       hi_hit_reg;
    logic [5:0] hi_idx_reg;
    logic       prio_hit_reg;
    logic [5:0] prio_code_reg;
    logic [5:0] low_idx_reg;
    logic       take_reg;
    logic       wake_reg;

    logic       done_reg;
    ids_pkg::ids_out_t result_reg;
    ids_pkg::ids_out_t result_next;

    // platform-defined causes, lowest first
    assign hi_hit_next = (sel_in.en & ids_pkg::PlatformMask) != 64'd0;
    assign hi_idx_next = ids_pkg::lowest_bit(sel_in.en & ids_pkg::PlatformMask);
    assign low_idx_next = ids_pkg::lowest_bit(sel_in.en);

    // standard causes in fixed order
    always_comb
    begin
        prio_hit_next  = 1'b0;
        prio_code_next = 6'd0;
        for (int i = ids_pkg::PrioCount - 1; i >= 0; i--)
        begin
            if (sel_in.en[ids_pkg::PrioOrder[i]])
            begin
                prio_hit_next  = 1'b1;
                prio_code_next = ids_pkg::PrioOrder[i];
            end
        end
    end

    // encode stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= sel_in.valid;
        end
    end

    // encode stage payload
    always_ff @(posedge clk)
    begin
        hi_hit_reg    <= hi_hit_next;
        hi_idx_reg    <= hi_idx_next;
        prio_hit_reg  <= prio_hit_next;
        prio_code_reg <= prio_code_next;
        low_idx_reg   <= low_idx_next;
        take_reg      <= sel_in.take;
        wake_reg      <= sel_in.wake;
    end

    // final cause select
    always_comb
    begin
        result_next      = '0;
        result_next.take = take_reg;
        result_next.wake = wake_reg;
        if (!take_reg)
        begin
            result_next.cause_code = 6'd0;
        end
        else if (hi_hit_reg)
        begin
            result_next.cause_code = hi_idx_reg;
        end
        else if (prio_hit_reg)
        begin
            result_next.cause_code = prio_code_reg;
        end
        else
        begin
            result_next.cause_code = low_idx_reg;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/interrupt_delegate_priority_select.sv
// top level of the interrupt delegate priority select pipeline
// depends on ids_pkg, ids_level_mask, ids_level_select, ids_encode
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  command  | start / busy       | cmd    (ids_pkg::ids_in_t)
//  result   | done (strobe)      | result (ids_pkg::ids_out_t)
//
// one command beat per cycle; busy is held low, so every start is taken
// each result passes through the four register stages: level masks,
// level select, priority encode, result
// the result is shown for one cycle with done; the receiver cannot stall
// reset clears the stage valid bits only; no state survives between beats
module interrupt_delegate_priority_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ids_pkg::ids_in_t  cmd,
    output logic              done,
    output ids_pkg::ids_out_t result
);

    ids_pkg::ids_mask_t mask_stage;
    ids_pkg::ids_sel_t  sel_stage;

    // pipeline never holds off a command
    assign busy = 1'b0;

    // level masking
    ids_level_mask u_level_mask (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stage (mask_stage)
    );

    // level selection
    ids_level_select u_level_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .mask_in (mask_stage),
        .stage   (sel_stage)
    );

    // priority encode and result register
    ids_encode u_encode (
        .clk    (clk),
        .rst_n  (rst_n),
        .sel_in (sel_stage),
        .done   (done),
        .result (result)
    );

    // every accepted command gives a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe missing after command");

    // no cause without a trap
    a_cause_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.take) |-> (result.cause_code == 6'd0))
        else $error("cause code set without trap");

    // a trap needs something pending
    a_take_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.take) |-> result.wake)
        else $error("trap taken with nothing pending");

    // trap never taken from a beat in debug mode
    a_debug_block: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cmd.in_debug) |-> ##4 !result.take)
        else $error("trap taken in debug mode");

endmodule

FILE: tb/ids_checker.sv
// checker for the interrupt delegate priority select block: watches the
// command and result beats, predicts each result and compares it
// depends on ids_pkg
module ids_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ids_pkg::ids_in_t  cmd,
    input  logic              done,
    input  ids_pkg::ids_out_t result,
    output int                error_count,
    output int                awaited,
    output int                checked_count,
    output int                taken_count
);
    timeunit 1ns;
    timeprecision 1ps;

    ids_pkg::ids_out_t irq_expected_q[$];
    ids_pkg::ids_out_t head_beat;
    int                fail_total;
    int                checked_total;
    int                taken_total;

    // lowest set bit at or above a floor, zero when none
    function automatic logic [5:0] first_set_from(input logic [63:0] v, input int floor_bit);
        logic [5:0] idx;
        logic       found;
        idx   = 6'd0;
        found = 1'b0;
        for (int i = floor_bit; i < 64; i++)
        begin
            if (!found && v[i])
            begin
                idx   = 6'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

    // choose the cause among the surviving bits of one level
    function automatic logic [5:0] choose_cause(input logic [63:0] en);
        logic [5:0] code;
        logic       found;
        found = 1'b0;
        code  = first_set_from(en, 0);
        // platform-defined causes outrank the standard ones
        if ((en & ids_pkg::PlatformMask) != 64'd0)
        begin
            code  = first_set_from(en, ids_pkg::PlatformBase);
            found = 1'b1;
        end
        for (int k = 0; k < ids_pkg::PrioCount; k++)
        begin
            if (!found && en[ids_pkg::PrioOrder[k]])
            begin
                code  = ids_pkg::PrioOrder[k];
                found = 1'b1;
            end
        end
        return code;
    endfunction

    // delegation filtering M, then HS, then VS while virtualised
    function automatic ids_pkg::ids_out_t predict_irq(input ids_pkg::ids_in_t c);
        logic [63:0]       pend;
        logic [63:0]       mdel;
        logic [63:0]       hdel;
        logic [63:0]       en;
        logic              m_ok;
        logic              hs_ok;
        logic              vs_ok;
        ids_pkg::ids_out_t r;
        pend  = c.pending & ids_pkg::XlenMask;
        mdel  = c.machine_delegation & ids_pkg::XlenMask;
        hdel  = c.hyper_delegation & ids_pkg::XlenMask;
        m_ok  = (c.priv_level < ids_pkg::PrivMachine) || c.machine_enable;
        hs_ok = c.virtualized || (c.priv_level < ids_pkg::PrivSuper)
                || (c.priv_level == ids_pkg::PrivSuper && c.super_enable);
        vs_ok = (c.priv_level < ids_pkg::PrivSuper)
                || (c.priv_level == ids_pkg::PrivSuper && c.super_enable);
        en = m_ok ? (pend & ~mdel) : 64'd0;
        if (en == 64'd0)
        begin
            en = hs_ok ? (pend & mdel & ~hdel) : 64'd0;
            if (c.virtualized && en == 64'd0)
            begin
                en = vs_ok ? (pend & hdel) : 64'd0;
            end
        end
        r.take       = !c.in_debug && c.nmi_enable && (en != 64'd0);
        r.cause_code = r.take ? choose_cause(en) : 6'd0;
        r.wake       = (pend != 64'd0);
        return r;
    endfunction

    // score results against the oldest prediction, then log new commands
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_expected_q.delete();
            fail_total    = 0;
            checked_total = 0;
            taken_total   = 0;
            error_count   <= 0;
            awaited       <= 0;
            checked_count <= 0;
            taken_count   <= 0;
        end
        else
        begin
            if (done)
            begin
                if (irq_expected_q.size() == 0)
                begin
                    $error("result beat with no command waiting: take %0d cause_code %0d wake %0d",
                           result.take, result.cause_code, result.wake);
                    fail_total++;
                end
                else
                begin
                    head_beat = irq_expected_q.pop_front();
                    checked_total++;
                    if (head_beat.take)
                    begin
                        taken_total++;
                    end
                    if (result.take !== head_beat.take)
                    begin
                        $error("take: expected %0d actual %0d", head_beat.take, result.take);
                        fail_total++;
                    end
                    if (result.cause_code !== head_beat.cause_code)
                    begin
                        $error("cause_code: expected %0d actual %0d",
                               head_beat.cause_code, result.cause_code);
                        fail_total++;
                    end
                    if (result.wake !== head_beat.wake)
                    begin
                        $error("wake: expected %0d actual %0d", head_beat.wake, result.wake);
                        fail_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                irq_expected_q.insert(irq_expected_q.size(), predict_irq(cmd));
            end
            error_count   <= fail_total;
            awaited       <= irq_expected_q.size();
            checked_count <= checked_total;
            taken_count   <= taken_total;
        end
    end

endmodule

FILE: tb/tb_top.sv
// top of the interrupt delegate priority select testbench: clock, reset,
// command stimulus and verdict
// depends on ids_pkg, ids_checker and interrupt_delegate_priority_select
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RandomItems  = 800;
    localparam int         CycleLimit   = 200000;
    localparam logic [1:0] PrivReserved = 2'd2;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    ids_pkg::ids_in_t  cmd;
    ids_pkg::ids_out_t result;
    int                error_count;
    int                awaited;
    int                checked_count;
    int                taken_count;
    int                cycle_count = 0;
    int                sent_count;
    int                idle_pct;
    logic [63:0]       std_irq_mask;

    interrupt_delegate_priority_select i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    ids_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .error_count   (error_count),
        .awaited       (awaited),
        .checked_count (checked_count),
        .taken_count   (taken_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic ids_pkg::ids_in_t make_cmd(input logic [63:0] pend,
                                                  input logic [63:0] mdel,
                                                  input logic [63:0] hdel, input logic mie,
                                                  input logic sie, input logic [1:0] priv,
                                                  input logic virt, input logic dbg,
                                                  input logic nmie);
        ids_pkg::ids_in_t c;
        c.pending            = pend;
        c.machine_delegation = mdel;
        c.hyper_delegation   = hdel;
        c.machine_enable     = mie;
        c.super_enable       = sie;
        c.priv_level         = priv;
        c.virtualized        = virt;
        c.in_debug           = dbg;
        c.nmi_enable         = nmie;
        return c;
    endfunction

    // random delegation mask: none, all, scattered or standard bits only
    function automatic logic [63:0] random_deleg();
        logic [63:0] m;
        case ($urandom_range(3))
            0:       m = 64'd0;
            1:       m = '1;
            2:       m = rand64();
            default: m = rand64() & std_irq_mask;
        endcase
        return m;
    endfunction

    // mostly sparse standard causes so the priority order gets exercised
    function automatic ids_pkg::ids_in_t random_cmd();
        logic [63:0] pend;
        case ($urandom_range(19))
            0, 1, 2, 3:    pend = rand64();
            4:             pend = 64'd0;
            5, 6:          pend = 64'd1 << $urandom_range(63);
            7, 8, 9:       pend = (rand64() & std_irq_mask) | (64'd1 << $urandom_range(63, 14));
            default:       pend = rand64() & std_irq_mask;
        endcase
        return make_cmd(pend, random_deleg(), random_deleg(), 1'($urandom), 1'($urandom),
                        2'($urandom_range(3)), 1'($urandom), $urandom_range(9) == 0,
                        $urandom_range(9) != 0);
    endfunction

    // one command beat, with random idle cycles ahead of it
    task automatic send_beat(input ids_pkg::ids_in_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            cmd   <= random_cmd();
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [63:0] keep;
        logic [63:0] bit_mei;
        logic [63:0] bit_sei;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        sent_count = 0;
        idle_pct   = 37;
        std_irq_mask = 64'd0;
        for (int k = 0; k < ids_pkg::PrioCount; k++)
        begin
            std_irq_mask[ids_pkg::PrioOrder[k]] = 1'b1;
        end
        bit_mei = 64'd1 << ids_pkg::IrqMei;
        bit_sei = 64'd1 << ids_pkg::IrqSei;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing pending, platform causes first, machine enable off
        send_beat(make_cmd(64'd0, 64'd0, 64'd0, 1'b1, 1'b1, ids_pkg::PrivMachine,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd('1, 64'd0, 64'd0, 1'b1, 1'b0, ids_pkg::PrivMachine,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd(64'd1 << 63, 64'd0, 64'd0, 1'b1, 1'b0, ids_pkg::PrivMachine,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd(64'd1 << 63, 64'd0, 64'd0, 1'b0, 1'b0, ids_pkg::PrivMachine,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd((64'd1 << 40) | (64'd1 << 20) | bit_mei, 64'd0, 64'd0,
                           1'b0, 1'b0, ids_pkg::PrivUser, 1'b0, 1'b0, 1'b1));
        // walk down the standard priority order
        keep = std_irq_mask;
        for (int k = 0; k < ids_pkg::PrioCount; k++)
        begin
            send_beat(make_cmd(keep, 64'd0, 64'd0, 1'b0, 1'b0, ids_pkg::PrivUser,
                               1'b0, 1'b0, 1'b1));
            keep[ids_pkg::PrioOrder[k]] = 1'b0;
        end
        // only non-standard low causes left
        send_beat(make_cmd(64'h1110, 64'd0, 64'd0, 1'b0, 1'b0, ids_pkg::PrivUser,
                           1'b0, 1'b0, 1'b1));
        // debug mode and NMI disable block the trap but not the wake
        send_beat(make_cmd('1, 64'd0, 64'd0, 1'b1, 1'b1, ids_pkg::PrivUser,
                           1'b0, 1'b1, 1'b1));
        send_beat(make_cmd('1, 64'd0, 64'd0, 1'b1, 1'b1, ids_pkg::PrivUser,
                           1'b0, 1'b0, 1'b0));
        // HS level with and without SIE, and from machine mode
        send_beat(make_cmd(std_irq_mask, '1, 64'd0, 1'b0, 1'b1, ids_pkg::PrivSuper,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd(std_irq_mask, '1, 64'd0, 1'b0, 1'b0, ids_pkg::PrivSuper,
                           1'b0, 1'b0, 1'b1));
        send_beat(make_cmd(std_irq_mask, '1, 64'd0, 1'b1, 1'b1, ids_pkg::PrivMachine,
                           1'b0, 1'b0, 1'b1));
        // VS level while virtualised
        send_beat(make_cmd(std_irq_mask, '1, '1, 1'b0, 1'b1, ids_pkg::PrivSuper,
                           1'b1, 1'b0, 1'b1));
        send_beat(make_cmd(std_irq_mask, '1, '1, 1'b0, 1'b0, ids_pkg::PrivSuper,
                           1'b1, 1'b0, 1'b1));
        // reserved privilege code
        send_beat(make_cmd(std_irq_mask, '1, 64'd0, 1'b0, 1'b0, PrivReserved,
                           1'b1, 1'b0, 1'b1));
        send_beat(make_cmd(std_irq_mask, '1, '1, 1'b0, 1'b1, PrivReserved,
                           1'b1, 1'b0, 1'b1));
        send_beat(make_cmd(std_irq_mask, 64'd0, 64'd0, 1'b0, 1'b0, PrivReserved,
                           1'b0, 1'b0, 1'b1));
        // split delegation: the machine cause goes down, the supervisor one stays
        send_beat(make_cmd(bit_mei | bit_sei, bit_mei, 64'd0, 1'b0, 1'b1, ids_pkg::PrivSuper,
                           1'b0, 1'b0, 1'b1));

        // random commands under three idling patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
            repeat (RandomItems / 3)
            begin
                send_beat(random_cmd());
            end
        end
        start <= 1'b0;

        // drain the pipeline
        while (awaited != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("sent %0d commands, checked %0d results, %0d of them traps", sent_count,
                 checked_count, taken_count);
        $display("covered M, HS and VS delegation, all privilege codes, debug and NMI blocking");
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
